>>> design/sliding_window_distinct_count_top_defines.svh
// assertion macros for the distinct count block
`ifndef SLIDING_WINDOW_DISTINCT_COUNT_TOP_DEFINES_SVH
`define SLIDING_WINDOW_DISTINCT_COUNT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SWDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`define SWDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define SWDC_ASSERT_NOW(label, ante, cons)
`define SWDC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/swdc_pkg.sv
package swdc_pkg;

  localparam int unsigned MAX_WINDOW_DEF    = 256;
  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned VALUE_W           = 32;
  localparam int unsigned CFG_W             = 9;
  localparam int unsigned COUNT_W           = 9;
  localparam int unsigned WINDOW_RESET      = 1;

  // table port control
  typedef struct packed {
    logic we;
    logic set_valid;
    logic clr_valid;
    logic clear_all;
  } tbl_ctl_t;

endpackage

>>> design/swdc_in_if.sv
interface swdc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [swdc_pkg::VALUE_W-1:0] value;
  logic                                restart;

  modport source (output valid, output value, output restart, input ready);
  modport sink   (input valid, input value, input restart, output ready);
endinterface

>>> design/swdc_out_if.sv
interface swdc_out_if;
  logic                         valid;
  logic                         ready;
  logic [swdc_pkg::COUNT_W-1:0] distinct_count;

  modport source (output valid, output distinct_count, input ready);
  modport sink   (input valid, input distinct_count, output ready);
endinterface

>>> design/sliding_window_distinct_count_top.sv
// each table probe is a memory read (S_ISSUE) then a compare (S_CMP); up to TABLE_ENTRIES probes
// per key, with the leaving key searched before the new one once the window is full
// throughput: one item at a time, the next accepted only back in S_IDLE; a new key
// scans the whole table, a known key stops at its entry; an untaken result holds the next item
// reset: synchronous active-low rst_n clears control, counters and table flags; window_size is 1
// a window_size write (taken only in S_IDLE) or a restart item empties window and table
`include "sliding_window_distinct_count_top_defines.svh"

module sliding_window_distinct_count_top #(
  parameter int unsigned MAX_WINDOW    = swdc_pkg::MAX_WINDOW_DEF,
  parameter int unsigned TABLE_ENTRIES = swdc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [swdc_pkg::CFG_W-1:0] cfg_wdata,
  swdc_in_if.sink                    in_ch,
  swdc_out_if.source                 out_ch
);

  localparam int unsigned WAW  = $clog2(MAX_WINDOW);        // window address
  localparam int unsigned WW   = $clog2(MAX_WINDOW + 1);    // window length / fill
  localparam int unsigned TAW  = $clog2(TABLE_ENTRIES);     // table address
  localparam int unsigned TW   = $clog2(TABLE_ENTRIES + 1); // distinct total
  localparam int unsigned CNTW = $clog2(MAX_WINDOW + 1);    // per-key count
  localparam int unsigned KW   = swdc_pkg::VALUE_W;
  localparam int unsigned OW   = swdc_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_OLD,
    S_ISSUE,
    S_CMP,
    S_FIN
  } state_t;

  state_t                     state_r;
  logic [swdc_pkg::CFG_W-1:0] wsize_r;
  logic [WAW-1:0]             slot_r;
  logic [WW-1:0]              samples_r;
  logic [TW-1:0]              total_r;
  logic [KW-1:0]              key_r;      // incoming value
  logic [KW-1:0]              srch_key_r; // key under search
  logic                       phase_add_r; // 0: removing old key, 1: adding new key
  logic [TAW-1:0]             addr_r;
  logic [TAW-1:0]             n_r;
  logic                       free_found_r;
  logic [TAW-1:0]             free_addr_r;
  logic                       out_valid_r;
  logic [OW-1:0]              out_data_r;

  // effective window length, zero taken as one, saturated to the store depth
  logic [WW-1:0] w_eff;
  always_comb begin
    if (wsize_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(wsize_r) > MAX_WINDOW) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(wsize_r);
    end
  end

  // probe start: low TAW key bits, brought below the table size by one compare and subtract
  function automatic logic [TAW-1:0] probe_start(input logic [KW-1:0] k);
    logic [TAW:0] low;
    low = {1'b0, k[TAW-1:0]};
    if (32'(low) >= TABLE_ENTRIES) begin
      low = low - (TAW+1)'(TABLE_ENTRIES);
    end
    return low[TAW-1:0];
  endfunction

  function automatic logic [TAW-1:0] probe_next(input logic [TAW-1:0] a);
    if (32'(a) == TABLE_ENTRIES - 1) begin
      return '0;
    end
    return a + TAW'(1);
  endfunction

  // accept stage view of the item after an optional restart
  logic           accept;
  logic [WAW-1:0] slot_eff;
  logic [WW-1:0]  samples_eff;
  logic [WAW-1:0] old_idx;
  logic [31:0]    old_sum;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_eff    = in_ch.restart ? '0 : slot_r;
  assign samples_eff = in_ch.restart ? '0 : samples_r;

  always_comb begin
    old_sum = 32'(slot_eff) + MAX_WINDOW - 32'(w_eff);
    if (old_sum >= MAX_WINDOW) begin
      old_sum = old_sum - MAX_WINDOW;
    end
    old_idx = old_sum[WAW-1:0];
  end

  // window delay line
  logic [KW-1:0] win_rdata;
  logic          push;
  logic          out_set;

  assign push    = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  // window full once this item is in: it yields a result
  assign out_set = push && (samples_r + WW'(1) >= w_eff);

  swdc_window #(
    .DEPTH (MAX_WINDOW),
    .AW    (WAW)
  ) u_window (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (old_idx),
    .rd_data (win_rdata),
    .we      (push),
    .wr_addr (slot_r),
    .wr_data (key_r)
  );

  // key table
  swdc_pkg::tbl_ctl_t tctl;
  logic [TAW-1:0]     t_wr_addr;
  logic [KW-1:0]      t_wr_key;
  logic [CNTW-1:0]    t_wr_count;
  logic [KW-1:0]      t_rd_key;
  logic [CNTW-1:0]    t_rd_count;
  logic               t_rd_valid;

  swdc_table #(
    .ENTRIES (TABLE_ENTRIES),
    .CNTW    (CNTW),
    .AW      (TAW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tctl),
    .rd_en    (state_r == S_ISSUE),
    .rd_addr  (addr_r),
    .rd_key   (t_rd_key),
    .rd_count (t_rd_count),
    .rd_valid (t_rd_valid),
    .wr_addr  (t_wr_addr),
    .wr_key   (t_wr_key),
    .wr_count (t_wr_count)
  );

  // compare stage decisions
  logic hit;
  logic last_probe;
  logic do_insert;

  assign hit        = (state_r == S_CMP) && t_rd_valid && (t_rd_key == srch_key_r);
  assign last_probe = (32'(n_r) == TABLE_ENTRIES - 1);
  assign do_insert  = (state_r == S_CMP) && phase_add_r && !hit && last_probe &&
                      (free_found_r || !t_rd_valid);

  always_comb begin
    tctl       = '0;
    t_wr_addr  = addr_r;
    t_wr_key   = srch_key_r;
    t_wr_count = t_rd_count;
    tctl.clear_all = (cfg_we && state_r == S_IDLE) || (accept && in_ch.restart);
    if (hit) begin
      tctl.we = 1'b1;
      if (phase_add_r) begin
        t_wr_count = t_rd_count + CNTW'(1);
      end else if (t_rd_count > CNTW'(1)) begin
        t_wr_count = t_rd_count - CNTW'(1);
      end else begin
        t_wr_count     = '0;
        tctl.clr_valid = 1'b1;
      end
    end else if (do_insert) begin
      // first free entry met on the scan, or this last one
      tctl.we        = 1'b1;
      tctl.set_valid = 1'b1;
      t_wr_addr      = free_found_r ? free_addr_r : addr_r;
      t_wr_count     = CNTW'(1);
    end
  end

  logic [TW+OW-1:0] total_ext;
  assign total_ext = (TW+OW)'(total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wsize_r      <= swdc_pkg::CFG_W'(swdc_pkg::WINDOW_RESET);
      slot_r       <= '0;
      samples_r    <= '0;
      total_r      <= '0;
      phase_add_r  <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      addr_r       <= '0;
      n_r          <= '0;
    end else begin
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cfg_we) begin
            wsize_r   <= cfg_wdata;
            slot_r    <= '0;
            samples_r <= '0;
            total_r   <= '0;
          end else if (accept) begin
            key_r        <= in_ch.value;
            n_r          <= '0;
            free_found_r <= 1'b0;
            if (in_ch.restart) begin
              slot_r    <= '0;
              samples_r <= '0;
              total_r   <= '0;
            end
            if (samples_eff >= w_eff) begin
              phase_add_r <= 1'b0;
              state_r     <= S_RD_OLD;
            end else begin
              phase_add_r <= 1'b1;
              srch_key_r  <= in_ch.value;
              addr_r      <= probe_start(in_ch.value);
              state_r     <= S_ISSUE;
            end
          end
        end
        S_RD_OLD: begin
          srch_key_r <= win_rdata;
          addr_r     <= probe_start(win_rdata);
          state_r    <= S_ISSUE;
        end
        S_ISSUE: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          // the last probe takes its own free entry directly
          if (!t_rd_valid && !free_found_r && !last_probe) begin
            free_found_r <= 1'b1;
            free_addr_r  <= addr_r;
          end
          if (hit || last_probe) begin
            if (hit && !phase_add_r && t_rd_count <= CNTW'(1) && total_r != '0) begin
              total_r <= total_r - TW'(1);
            end
            if (do_insert) begin
              total_r <= total_r + TW'(1);
            end
            if (phase_add_r) begin
              state_r <= S_FIN;
            end else begin
              // old key done, now the incoming one
              phase_add_r  <= 1'b1;
              srch_key_r   <= key_r;
              addr_r       <= probe_start(key_r);
              n_r          <= '0;
              free_found_r <= 1'b0;
              state_r      <= S_ISSUE;
            end
          end else begin
            addr_r  <= probe_next(addr_r);
            n_r     <= n_r + TAW'(1);
            state_r <= S_ISSUE;
          end
        end
        S_FIN: begin
          if (push) begin
            slot_r <= (32'(slot_r) == MAX_WINDOW - 1) ? '0 : slot_r + WAW'(1);
            if (samples_r < w_eff) begin
              samples_r <= samples_r + WW'(1);
            end
            if (out_set) begin
              out_data_r <= total_ext[OW-1:0];
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.distinct_count = out_data_r;

  `SWDC_ASSERT_NOW(a_total_bound, 1'b1, 32'(total_r) <= TABLE_ENTRIES)
  `SWDC_ASSERT_NOW(a_fill_bound, state_r != S_IDLE, samples_r <= w_eff)
  `SWDC_ASSERT_NEXT(a_push_idle, push, state_r == S_IDLE)
  `SWDC_ASSERT_NOW(a_hit_add_only_in_cmp, hit || do_insert, state_r == S_CMP)

endmodule

>>> design/swdc_window.sv
module swdc_window #(
  parameter int unsigned DEPTH = swdc_pkg::MAX_WINDOW_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [swdc_pkg::VALUE_W-1:0] rd_data,
  input  logic                         we,
  input  logic [AW-1:0]                wr_addr,
  input  logic [swdc_pkg::VALUE_W-1:0] wr_data
);

  logic [swdc_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/swdc_table.sv
module swdc_table #(
  parameter int unsigned ENTRIES = swdc_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned CNTW    = 9,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  swdc_pkg::tbl_ctl_t           ctl,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [swdc_pkg::VALUE_W-1:0] rd_key,
  output logic [CNTW-1:0]              rd_count,
  output logic                         rd_valid,
  input  logic [AW-1:0]                wr_addr,
  input  logic [swdc_pkg::VALUE_W-1:0] wr_key,
  input  logic [CNTW-1:0]              wr_count
);

  logic [swdc_pkg::VALUE_W+CNTW-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0]                valid_r;

  // key and count share one entry
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[wr_addr] <= {wr_key, wr_count};
    end
    if (rd_en) begin
      {rd_key, rd_count} <= mem[rd_addr];
    end
  end

  // occupancy flags cleared at once on reset or on clear_all (restart or window write)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctl.clear_all) begin
        valid_r <= '0;
      end else if (ctl.set_valid) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (ctl.clr_valid) begin
        valid_r[wr_addr] <= 1'b0;
      end
      if (rd_en) begin
        rd_valid <= valid_r[rd_addr];
      end
    end
  end

endmodule

>>> verif/tb_sliding_window_distinct_count_top.sv
module tb_sliding_window_distinct_count_top;

  localparam int unsigned CFG_W      = swdc_pkg::CFG_W;
  localparam int unsigned VALUE_W    = swdc_pkg::VALUE_W;
  localparam int unsigned COUNT_W    = swdc_pkg::COUNT_W;
  localparam int unsigned WIN_MAX    = swdc_pkg::MAX_WINDOW_DEF;
  localparam int unsigned TBL_SIZE   = swdc_pkg::TABLE_ENTRIES_DEF;
  // worst probe time for one item: a full table scan for the leaving and the new key
  localparam int unsigned SETTLE     = 2 * (4 + 4 * TBL_SIZE) + 50;
  localparam int unsigned STALL_STOP = 20000;
  localparam int unsigned RAND_ITEMS = 1700;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  swdc_in_if  in_ch ();
  swdc_out_if out_ch ();

  sliding_window_distinct_count_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  // shadow of the block: delay line, key table and counters
  logic [CFG_W-1:0]   win_reg;
  logic [VALUE_W-1:0] line_mem [WIN_MAX];
  logic [VALUE_W-1:0] key_mem  [TBL_SIZE];
  int unsigned        occ_mem  [TBL_SIZE];
  bit                 used_mem [TBL_SIZE];
  int unsigned        distinct_now;
  int unsigned        fill_level;
  int unsigned        slot_ptr;

  // distinct counts still to come out of the block, oldest first
  logic [COUNT_W-1:0] pending_counts [$];

  int unsigned errors;
  int unsigned idle_cycles;
  bit          quiet_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // most gaps short, a few long, none while quiet_mode is set
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void empty_window();
    for (int i = 0; i < TBL_SIZE; i++) begin
      used_mem[i] = 1'b0;
      occ_mem[i]  = 0;
    end
    distinct_now = 0;
    fill_level   = 0;
    slot_ptr     = 0;
  endfunction

  function automatic int unsigned window_len();
    if (win_reg == 0) return 1;
    if (win_reg > WIN_MAX) return WIN_MAX;
    return win_reg;
  endfunction

  // entry holding the key, or TBL_SIZE when absent
  function automatic int unsigned find_key(input logic [VALUE_W-1:0] key);
    int unsigned e;
    for (int n = 0; n < TBL_SIZE; n++) begin
      e = (key + n) % TBL_SIZE;
      if (used_mem[e] && key_mem[e] == key) return e;
    end
    return TBL_SIZE;
  endfunction

  function automatic void count_in(input logic [VALUE_W-1:0] key);
    int unsigned e;
    e = find_key(key);
    if (e < TBL_SIZE) begin
      occ_mem[e]++;
      return;
    end
    for (int n = 0; n < TBL_SIZE; n++) begin
      e = (key + n) % TBL_SIZE;
      if (!used_mem[e]) begin
        used_mem[e] = 1'b1;
        key_mem[e]  = key;
        occ_mem[e]  = 1;
        distinct_now++;
        return;
      end
    end
    // no free entry: the key is dropped
  endfunction

  function automatic void count_out(input logic [VALUE_W-1:0] key);
    int unsigned e;
    e = find_key(key);
    if (e >= TBL_SIZE) return;
    if (occ_mem[e] > 1) occ_mem[e]--;
    else begin
      occ_mem[e]  = 0;
      used_mem[e] = 1'b0;
      if (distinct_now > 0) distinct_now--;
    end
  endfunction

  function automatic void predict_count(input logic [VALUE_W-1:0] value, input bit restart);
    int unsigned w;
    w = window_len();
    if (restart) empty_window();
    if (fill_level >= w) count_out(line_mem[(slot_ptr + WIN_MAX - w) % WIN_MAX]);
    count_in(value);
    line_mem[slot_ptr] = value;
    slot_ptr = (slot_ptr + 1) % WIN_MAX;
    if (fill_level < w) fill_level++;
    if (fill_level >= w) pending_counts = {pending_counts, distinct_now[COUNT_W-1:0]};
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [VALUE_W-1:0] value, input bit restart = 1'b0);
    int unsigned gap;
    in_ch.valid   = 1'b1;
    in_ch.value   = value;
    in_ch.restart = restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_count(value, restart);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // wait for every count, then for any probe still running on an item with no result
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // a window write also empties window and table
  task automatic write_window(input logic [CFG_W-1:0] w);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = w;
    @(negedge clk);
    cfg_we  = 1'b0;
    win_reg = w;
    empty_window();
  endtask

  // value from a small pool or its negation, a shared hash slot, or the full range
  function automatic logic [VALUE_W-1:0] pick_value(input int unsigned pool);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, pool);
    if (r < 80) return -$urandom_range(0, pool);
    if (r < 90) return ($urandom_range(0, 3) << 8) | 8'h5A;
    return $urandom();
  endfunction

  // reset window of one, field extremes
  task automatic test_extremes();
    send_item(32'h0000_0000);
    send_item(32'h7FFF_FFFF);
    send_item(32'h8000_0000);
    send_item(32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF);
    send_item(32'hAAAA_AAAA, 1'b1);
    send_item(32'h5555_5555);
  endtask

  // zero counts as one, repeated zeros count once, a restart empties the window
  task automatic test_window_limits();
    write_window(9'd0);
    send_item(32'd0);
    send_item(32'd0);
    write_window(9'd3);
    send_item(32'd0);
    send_item(32'd0);
    send_item(32'd0);
    send_item(32'd7);
    send_item(32'd0, 1'b1);
    send_item(32'd9);
    send_item(32'd9);
  endtask

  // keys sharing one start entry, removal of the head of the chain
  task automatic test_collisions();
    write_window(9'd4);
    send_item(32'h0000_0105);
    send_item(32'h0000_0205);
    send_item(32'h0000_0305);
    send_item(32'h0000_0405);
    send_item(32'h0000_0205);
    send_item(32'h0000_0305);
    send_item(32'h0000_0505);
  endtask

  // largest window, all distinct to reach the top count, then repeats
  task automatic test_full_window();
    write_window(9'd511);
    for (int i = 0; i < WIN_MAX; i++) send_item(32'h1000_0000 + i);
    for (int i = 0; i < 20; i++) send_item(32'h1000_0000 + $urandom_range(0, 300));
    write_window(9'd256);
    for (int i = 0; i < 30; i++) send_item($urandom_range(0, 5));
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned len;
    int unsigned pool;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 7))
        0: write_window(9'd1);
        1: write_window(9'd2);
        2: write_window(9'd0);
        3: write_window(9'd511);
        default: write_window(CFG_W'($urandom_range(1, 40)));
      endcase
      quiet_mode = ($urandom_range(0, 3) == 0);
      pool = $urandom_range(1, 20);
      len  = $urandom_range(30, 150);
      for (int i = 0; i < len; i++) begin
        send_item(pick_value(pool), $urandom_range(0, 99) < 3);
        sent++;
      end
      quiet_mode = 1'b0;
    end
  endtask

  // result side: random back-pressure
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  // compare each count against the oldest one predicted
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_counts.size() == 0) report("count with none expected");
      else begin
        if (out_ch.distinct_count !== pending_counts[0])
          report($sformatf("distinct_count got %0d want %0d",
                           out_ch.distinct_count, pending_counts[0]));
        void'(pending_counts.pop_front());
      end
    end
  end

  // stall watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_STOP) begin
      $display("status: fail");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    errors        = 0;
    idle_cycles   = 0;
    quiet_mode    = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.restart = 1'b0;
    win_reg       = CFG_W'(swdc_pkg::WINDOW_RESET);
    empty_window();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_window_limits();
    test_collisions();
    test_full_window();
    test_random();
    drain();

    if (pending_counts.size() != 0) report("counts never produced");
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
